// File: hw/rtl/erma_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler rotation block.
package erma_pkg;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [33:0] cordic_t;
  typedef logic signed [16:0] rot_t;

  localparam int TrigIterDefault = 16;
  localparam int AtanEntries     = 24;
  localparam cordic_t CordicStart = 34'sd652032874;
  localparam int Q14One          = 16384;

  // Arctangent of 2^-i, a full turn is 2^32.
  function automatic cordic_t atan_turn(input int idx);
    cordic_t r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half up by 2^sh, then clamp to +-1.0 in Q2.14.
  function automatic q14_t rnd_q14(input logic signed [47:0] v, input int sh);
    logic signed [47:0] r;
    logic signed [47:0] half;
    half = 48'sd1 <<< (sh - 1);
    r = (v + half) >>> sh;
    if (r > 48'sd16384) begin
      return 16'sd16384;
    end else if (r < -48'sd16384) begin
      return -16'sd16384;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage

// File: hw/rtl/euler_rotation_matrix_apply.sv
// Top level: ZYX Euler rotation matrix and vector rotation, fully pipelined.
//
//  channel | signals                              | direction
//  input   | in_valid_i, in_stall_o, angles, vec  | into block
//  output  | out_valid_o, out_stall_i, mat, rot   | out of block
//
// One item per cycle while the output is not stalled; the stages are the
// input stage, the CORDIC steps, the quadrant stage, three matrix and two vector stages.
// Reset clears only the valid bits of every stage.
// A stall while the output is valid freezes the whole pipeline; in_stall_o follows it.
module euler_rotation_matrix_apply #(
  parameter int TrigIter = erma_pkg::TrigIterDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [15:0]    angle_one_i,
  input  logic [15:0]    angle_two_i,
  input  logic [15:0]    angle_three_i,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic signed [15:0] mat_0_o,
  output logic signed [15:0] mat_1_o,
  output logic signed [15:0] mat_2_o,
  output logic signed [15:0] mat_3_o,
  output logic signed [15:0] mat_4_o,
  output logic signed [15:0] mat_5_o,
  output logic signed [15:0] mat_6_o,
  output logic signed [15:0] mat_7_o,
  output logic signed [15:0] mat_8_o,
  output logic signed [16:0] rot_x_o,
  output logic signed [16:0] rot_y_o,
  output logic signed [16:0] rot_z_o
);

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [15:0] angle [3];
  assign angle[0] = angle_one_i;
  assign angle[1] = angle_two_i;
  assign angle[2] = angle_three_i;

  logic           trig_valid, mat_valid;
  erma_pkg::q14_t sin_v [3];
  erma_pkg::q14_t cos_v [3];
  logic [47:0]    trig_vec, mat_vec;
  erma_pkg::q14_t mat_v [9];
  erma_pkg::q14_t mat_out [9];
  erma_pkg::rot_t rot_v [3];

  erma_trig #(.Iter(TrigIter)) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (angle),
    .vec_i   ({vec_z_i, vec_y_i, vec_x_i}),
    .valid_o (trig_valid),
    .sin_o   (sin_v),
    .cos_o   (cos_v),
    .vec_o   (trig_vec)
  );

  erma_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (trig_valid),
    .sin_i   (sin_v),
    .cos_i   (cos_v),
    .vec_i   (trig_vec),
    .valid_o (mat_valid),
    .mat_o   (mat_v),
    .vec_o   (mat_vec)
  );

  erma_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_valid),
    .mat_i   (mat_v),
    .vec_i   (mat_vec),
    .valid_o (out_valid_o),
    .mat_o   (mat_out),
    .rot_o   (rot_v)
  );

  assign mat_0_o = mat_out[0];
  assign mat_1_o = mat_out[1];
  assign mat_2_o = mat_out[2];
  assign mat_3_o = mat_out[3];
  assign mat_4_o = mat_out[4];
  assign mat_5_o = mat_out[5];
  assign mat_6_o = mat_out[6];
  assign mat_7_o = mat_out[7];
  assign mat_8_o = mat_out[8];
  assign rot_x_o = rot_v[0];
  assign rot_y_o = rot_v[1];
  assign rot_z_o = rot_v[2];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output stage");

  a_mat0_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mat_0_o <= 16'sd16384 && mat_0_o >= -16'sd16384))
    else $error("mat_0 out of range");

  a_mat4_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mat_4_o <= 16'sd16384 && mat_4_o >= -16'sd16384))
    else $error("mat_4 out of range");

  a_frozen_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(rot_x_o) && $stable(mat_1_o)))
    else $error("pipeline moved during stall");

endmodule

// File: hw/rtl/erma_trig.sv
// Pipelined CORDIC: sine and cosine of three binary angles, one step per stage.
module erma_trig #(
  parameter int Iter = erma_pkg::TrigIterDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [15:0]         angle_i [3],
  input  logic [47:0]         vec_i,
  output logic                valid_o,
  output erma_pkg::q14_t      sin_o [3],
  output erma_pkg::q14_t      cos_o [3],
  output logic [47:0]         vec_o
);

  localparam int N = (Iter < erma_pkg::AtanEntries) ? Iter : erma_pkg::AtanEntries;

  erma_pkg::cordic_t x_q [N+1][3];
  erma_pkg::cordic_t y_q [N+1][3];
  erma_pkg::cordic_t z_q [N+1][3];
  logic [1:0]        quad_q [N+1][3];
  logic [47:0]       vec_q [N+1];
  logic [N+1:0]      valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q[0] <= vec_i;
      for (int k = 0; k < 3; k++) begin
        x_q[0][k]    <= erma_pkg::CordicStart;
        y_q[0][k]    <= '0;
        z_q[0][k]    <= erma_pkg::cordic_t'({angle_i[k][13:0], 16'h0000});
        quad_q[0][k] <= angle_i[k][15:14];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[i+1] <= vec_q[i];
        for (int k = 0; k < 3; k++) begin
          quad_q[i+1][k] <= quad_q[i][k];
          // zero remaining angle counts as positive
          if (!z_q[i][k][33]) begin
            x_q[i+1][k] <= x_q[i][k] - (y_q[i][k] >>> i);
            y_q[i+1][k] <= y_q[i][k] + (x_q[i][k] >>> i);
            z_q[i+1][k] <= z_q[i][k] - erma_pkg::atan_turn(i);
          end else begin
            x_q[i+1][k] <= x_q[i][k] + (y_q[i][k] >>> i);
            y_q[i+1][k] <= y_q[i][k] - (x_q[i][k] >>> i);
            z_q[i+1][k] <= z_q[i][k] + erma_pkg::atan_turn(i);
          end
        end
      end
    end
  end

  erma_pkg::q14_t sin_q [3];
  erma_pkg::q14_t cos_q [3];
  logic [47:0]    vec_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_out_q <= vec_q[N];
      for (int k = 0; k < 3; k++) begin
        case (quad_q[N][k])
          2'd0: begin
            cos_q[k] <= erma_pkg::rnd_q14(48'(x_q[N][k]), 16);
            sin_q[k] <= erma_pkg::rnd_q14(48'(y_q[N][k]), 16);
          end
          2'd1: begin
            cos_q[k] <= -erma_pkg::rnd_q14(48'(y_q[N][k]), 16);
            sin_q[k] <= erma_pkg::rnd_q14(48'(x_q[N][k]), 16);
          end
          2'd2: begin
            cos_q[k] <= -erma_pkg::rnd_q14(48'(x_q[N][k]), 16);
            sin_q[k] <= -erma_pkg::rnd_q14(48'(y_q[N][k]), 16);
          end
          default: begin
            cos_q[k] <= erma_pkg::rnd_q14(48'(y_q[N][k]), 16);
            sin_q[k] <= -erma_pkg::rnd_q14(48'(x_q[N][k]), 16);
          end
        endcase
      end
    end
  end

  assign valid_o = valid_q[N+1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign vec_o   = vec_out_q;

endmodule

// File: hw/rtl/erma_matrix.sv
// Rotation matrix from sines and cosines: pair products, triple products, rounding.
module erma_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  erma_pkg::q14_t sin_i [3],
  input  erma_pkg::q14_t cos_i [3],
  input  logic [47:0]    vec_i,
  output logic           valid_o,
  output erma_pkg::q14_t mat_o [9],
  output logic [47:0]    vec_o
);

  typedef logic signed [31:0] prod_t;
  typedef logic signed [47:0] wide_t;

  logic [2:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // stage 1: pair products
  prod_t s2s1_q, s3s2_q, s2c3_q, s3c1_q, c3c1_q, s1c3_q, s3s1_q;
  prod_t c3c2_q, s3c2_q, s1c2_q, c2c1_q;
  erma_pkg::q14_t s1_q, c1_q, c3_q, s2_q;
  logic [47:0] vec1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2s1_q <= 32'(sin_i[1] * sin_i[0]);
      s3s2_q <= 32'(sin_i[2] * sin_i[1]);
      s2c3_q <= 32'(sin_i[1] * cos_i[2]);
      s3c1_q <= 32'(sin_i[2] * cos_i[0]);
      c3c1_q <= 32'(cos_i[2] * cos_i[0]);
      s1c3_q <= 32'(sin_i[0] * cos_i[2]);
      s3s1_q <= 32'(sin_i[2] * sin_i[0]);
      c3c2_q <= 32'(cos_i[2] * cos_i[1]);
      s3c2_q <= 32'(sin_i[2] * cos_i[1]);
      s1c2_q <= 32'(sin_i[0] * cos_i[1]);
      c2c1_q <= 32'(cos_i[1] * cos_i[0]);
      s1_q   <= sin_i[0];
      c1_q   <= cos_i[0];
      c3_q   <= cos_i[2];
      s2_q   <= sin_i[1];
      vec1_q <= vec_i;
    end
  end

  // stage 2: triple products in Q42, pair entries rounded
  wide_t sum1_q, sum2_q, sum4_q, sum5_q;
  erma_pkg::q14_t m0_q, m3_q, m6_q, m7_q, m8_q;
  logic [47:0] vec2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum1_q <= wide_t'(s2s1_q) * wide_t'(c3_q) - (wide_t'(s3c1_q) <<< 14);
      sum4_q <= wide_t'(s3s2_q) * wide_t'(s1_q) + (wide_t'(c3c1_q) <<< 14);
      sum2_q <= wide_t'(s2c3_q) * wide_t'(c1_q) + (wide_t'(s3s1_q) <<< 14);
      sum5_q <= wide_t'(s3s2_q) * wide_t'(c1_q) - (wide_t'(s1c3_q) <<< 14);
      m0_q   <= erma_pkg::rnd_q14(wide_t'(c3c2_q), 14);
      m3_q   <= erma_pkg::rnd_q14(wide_t'(s3c2_q), 14);
      m7_q   <= erma_pkg::rnd_q14(wide_t'(s1c2_q), 14);
      m8_q   <= erma_pkg::rnd_q14(wide_t'(c2c1_q), 14);
      m6_q   <= -s2_q;
      vec2_q <= vec1_q;
    end
  end

  // stage 3: round the triple sums
  erma_pkg::q14_t mat_q [9];
  logic [47:0] vec3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q[0] <= m0_q;
      mat_q[1] <= erma_pkg::rnd_q14(sum1_q, 28);
      mat_q[2] <= erma_pkg::rnd_q14(sum2_q, 28);
      mat_q[3] <= m3_q;
      mat_q[4] <= erma_pkg::rnd_q14(sum4_q, 28);
      mat_q[5] <= erma_pkg::rnd_q14(sum5_q, 28);
      mat_q[6] <= m6_q;
      mat_q[7] <= m7_q;
      mat_q[8] <= m8_q;
      vec3_q   <= vec2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign mat_o   = mat_q;
  assign vec_o   = vec3_q;

endmodule

// File: hw/rtl/erma_rotate.sv
// Row vector times matrix: nine products, then rounded and saturated sums.
module erma_rotate (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  erma_pkg::q14_t mat_i [9],
  input  logic [47:0]    vec_i,
  output logic           valid_o,
  output erma_pkg::q14_t mat_o [9],
  output erma_pkg::rot_t rot_o [3]
);

  logic [1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  logic signed [15:0] comp [3];
  assign comp[0] = vec_i[15:0];
  assign comp[1] = vec_i[31:16];
  assign comp[2] = vec_i[47:32];

  logic signed [31:0] prod_q [9];
  erma_pkg::q14_t     mat1_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        prod_q[i] <= 32'(mat_i[i] * comp[i/3]);
        mat1_q[i] <= mat_i[i];
      end
    end
  end

  logic signed [33:0] acc [3];
  logic signed [33:0] scl [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = 34'(prod_q[k]) + 34'(prod_q[3+k]) + 34'(prod_q[6+k]);
      scl[k] = (acc[k] + 34'sd8192) >>> 14;
    end
  end

  erma_pkg::rot_t rot_q  [3];
  erma_pkg::q14_t mat2_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat2_q <= mat1_q;
      for (int k = 0; k < 3; k++) begin
        if (scl[k] > 34'sd65535) begin
          rot_q[k] <= 17'sd65535;
        end else if (scl[k] < -34'sd65536) begin
          rot_q[k] <= -17'sd65536;
        end else begin
          rot_q[k] <= scl[k][16:0];
        end
      end
    end
  end

  assign valid_o = valid_q[1];
  assign mat_o   = mat2_q;
  assign rot_o   = rot_q;

endmodule
